/* rtl/hla_pkg.sv */
// Package for the Hough line accumulator: sizes, field widths, codes, the
// controller state type, the command/status structs and the Q2.16 cos/sin table.
// Depends on nothing; every other file of the block imports it.
`default_nettype none

package hla_pkg;

  // Accumulator geometry.
  localparam int NTHETA   = 180;
  localparam int RHO_HALF = 364;
  localparam int MAX_DIM  = 256;
  localparam int NRHO     = 2 * RHO_HALF + 1;
  localparam int NCELL    = NTHETA * NRHO;

  // Field widths of the channels and the configuration port.
  localparam int KIND_W    = 2;
  localparam int COORD_W   = 9;
  localparam int PIX_W     = 8;
  localparam int ANGF_W    = 8;
  localparam int RHOF_W    = 10;
  localparam int COUNT_W   = 16;
  localparam int CFG_W     = 9;
  localparam int CFG_IDX_W = 1;
  localparam int IN_DATA_W  = 48;
  localparam int OUT_DATA_W = 16;

  // Internal widths.
  localparam int ANG_W  = $clog2(NTHETA);
  localparam int ROW_W  = $clog2(NRHO);
  localparam int ADDR_W = $clog2(NCELL);
  localparam int TRIG_W = 18;
  localparam int Q_FRAC = 16;
  localparam int PROD_W = COORD_W + 1 + TRIG_W;
  localparam int SUM_W  = PROD_W + 1;
  localparam int MAG_W  = SUM_W + 1 - Q_FRAC;

  // Request kinds.
  localparam logic [KIND_W-1:0] KIND_VOTE  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_READ  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 1'd1;
  localparam logic [CFG_W-1:0]     CFG_DIM_RESET    = 9'd256;

  typedef enum logic [2:0] {
    S_INIT_CLR,
    S_IDLE,
    S_DECODE,
    S_VOTE,
    S_DRAIN,
    S_CLR,
    S_RD_MEM,
    S_DONE
  } ctl_state_t;

  typedef enum logic [1:0] {
    RES_OK,
    RES_ERR,
    RES_COUNT
  } res_sel_t;

  // Controller to datapath.
  typedef struct packed {
    logic     capture;
    logic     ang_step;
    logic     clr_step;
    logic     rd_issue;
    logic     out_load;
    res_sel_t res_sel;
  } hla_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic              in_range;
    logic              pix_nz;
    logic              rd_ok;
    logic              ang_last;
    logic              clr_last;
    logic              pipe_busy;
  } hla_sts_t;

  typedef logic [2*TRIG_W-1:0] trig_rom_t [NTHETA];

  localparam longint unsigned PI_Q30  = 64'd3373259426;
  localparam longint unsigned ONE_Q30 = 64'd1073741824;
  localparam int              TAYLOR_TERMS = 12;
  localparam longint unsigned ANG_DIV = 2 * NTHETA;

  // Factorial steps of the series terms: (2k-1)(2k) for cos, (2k)(2k+1) for sin.
  localparam longint unsigned COS_DIV [TAYLOR_TERMS] = '{
    64'd2, 64'd12, 64'd30, 64'd56, 64'd90, 64'd132,
    64'd182, 64'd240, 64'd306, 64'd380, 64'd462, 64'd552
  };
  localparam longint unsigned SIN_DIV [TAYLOR_TERMS] = '{
    64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156,
    64'd210, 64'd272, 64'd342, 64'd420, 64'd506, 64'd600
  };

  // Each entry is {sin, cos}, both signed Q2.16. The angle is folded into
  // the first quadrant, a truncating Taylor series is summed in Q30 and the
  // sums are rounded to Q16; cos is negated above a right angle.
  function automatic trig_rom_t build_trig_rom();
    trig_rom_t         rom;
    longint unsigned   tf;
    longint unsigned   ang;
    longint unsigned   x2;
    longint unsigned   tc;
    longint unsigned   ts;
    longint            sc;
    longint            ss;
    longint unsigned   cq;
    longint unsigned   sq;
    logic              upper;
    logic [TRIG_W-1:0] cv;
    logic [TRIG_W-1:0] sv;
    for (int t = 0; t < NTHETA; t++) begin
      upper = (2 * t > NTHETA);
      tf    = upper ? longint'(NTHETA - t) : longint'(t);
      ang   = (2 * PI_Q30 * tf + NTHETA) / ANG_DIV;
      x2    = (ang * ang) >> 30;
      tc    = ONE_Q30;
      ts    = ang;
      sc    = longint'(ONE_Q30);
      ss    = longint'(ang);
      for (int k = 1; k <= TAYLOR_TERMS; k++) begin
        tc = ((tc * x2) >> 30) / COS_DIV[k - 1];
        ts = ((ts * x2) >> 30) / SIN_DIV[k - 1];
        if (k % 2 == 1) begin
          sc = sc - longint'(tc);
          ss = ss - longint'(ts);
        end else begin
          sc = sc + longint'(tc);
          ss = ss + longint'(ts);
        end
      end
      if (sc < 0) sc = 0;
      if (ss < 0) ss = 0;
      cq = (longint'(sc) + 8192) >> 14;
      sq = (longint'(ss) + 8192) >> 14;
      cv = upper ? -cq[TRIG_W-1:0] : cq[TRIG_W-1:0];
      sv = sq[TRIG_W-1:0];
      rom[t] = {sv, cv};
    end
    return rom;
  endfunction

  localparam trig_rom_t TRIG_ROM = build_trig_rom();

endpackage

`default_nettype wire

/* rtl/hla_ctrl.sv */
// Controller of the Hough line accumulator: request sequencing, clearing
// passes and the output valid flag. Depends on hla_pkg.
`default_nettype none

module hla_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_tvalid,
  output logic                   in_tready,
  output logic                   out_tvalid,
  input  wire logic              out_tready,
  input  wire hla_pkg::hla_sts_t sts,
  output hla_pkg::hla_cmd_t      cmd
);
  import hla_pkg::*;

  ctl_state_t state_r, state_nxt;
  res_sel_t   sel_r, sel_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       out_free;

  assign out_free = !out_valid_r || out_tready;

  always_comb begin
    state_nxt = state_r;
    sel_nxt   = sel_r;
    unique case (state_r)
      S_INIT_CLR: if (sts.clr_last) state_nxt = S_IDLE;
      S_IDLE:     if (in_tvalid) state_nxt = S_DECODE;
      S_DECODE: begin
        unique case (sts.kind)
          KIND_VOTE: begin
            if (!sts.in_range) begin
              sel_nxt   = RES_ERR;
              state_nxt = S_DONE;
            end else if (!sts.pix_nz) begin
              sel_nxt   = RES_OK;
              state_nxt = S_DONE;
            end else begin
              sel_nxt   = RES_OK;
              state_nxt = S_VOTE;
            end
          end
          KIND_READ: begin
            if (sts.rd_ok) begin
              sel_nxt   = RES_COUNT;
              state_nxt = S_RD_MEM;
            end else begin
              sel_nxt   = RES_ERR;
              state_nxt = S_DONE;
            end
          end
          KIND_CLEAR: begin
            sel_nxt   = RES_OK;
            state_nxt = S_CLR;
          end
          default: begin
            sel_nxt   = RES_OK;
            state_nxt = S_DONE;
          end
        endcase
      end
      S_VOTE:   if (sts.ang_last) state_nxt = S_DRAIN;
      S_DRAIN:  if (!sts.pipe_busy) state_nxt = S_DONE;
      S_CLR:    if (sts.clr_last) state_nxt = S_DONE;
      S_RD_MEM: state_nxt = S_DONE;
      S_DONE:   if (out_free) state_nxt = S_IDLE;
      default:  state_nxt = S_INIT_CLR;
    endcase
  end

  always_comb begin
    cmd          = '0;
    cmd.res_sel  = sel_r;
    cmd.capture  = (state_r == S_IDLE) && in_tvalid;
    cmd.ang_step = (state_r == S_VOTE);
    cmd.clr_step = (state_r == S_INIT_CLR) || (state_r == S_CLR);
    cmd.rd_issue = (state_r == S_RD_MEM);
    cmd.out_load = (state_r == S_DONE) && out_free;
    in_tready    = (state_r == S_IDLE);
    out_tvalid   = out_valid_r;
  end

  always_comb begin
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_INIT_CLR;
      sel_r       <= RES_OK;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      sel_r       <= sel_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

`default_nettype wire

/* rtl/hla_dp.sv */
// Datapath of the Hough line accumulator: configuration registers, request
// capture, the per-angle vote pipeline, the accumulator memory and the
// result register. Depends on hla_pkg.
`default_nettype none

module hla_dp (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              cfg_we,
  input  wire logic [hla_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [hla_pkg::CFG_W-1:0]         cfg_wdata,
  input  wire logic [hla_pkg::KIND_W-1:0]        in_kind,
  input  wire logic [hla_pkg::COORD_W-1:0]       in_pos_x,
  input  wire logic [hla_pkg::COORD_W-1:0]       in_pos_y,
  input  wire logic [hla_pkg::PIX_W-1:0]         in_pixel,
  input  wire logic [hla_pkg::ANGF_W-1:0]        in_angle_index,
  input  wire logic [hla_pkg::RHOF_W-1:0]        in_rho_index,
  input  wire hla_pkg::hla_cmd_t                 cmd,
  output hla_pkg::hla_sts_t                      sts,
  output logic [hla_pkg::COUNT_W-1:0]            out_count,
  output logic                                   out_status
);
  import hla_pkg::*;

  localparam logic [CFG_W-1:0] DIM_LIM = CFG_W'(MAX_DIM);

  logic [CFG_W-1:0]   width_r, height_r;

  logic [KIND_W-1:0]  kind_r;
  logic [COORD_W-1:0] x_r, y_r;
  logic [PIX_W-1:0]   pix_r;
  logic [ANGF_W-1:0]  angf_r;
  logic [RHOF_W-1:0]  rhof_r;

  logic [ANG_W-1:0]   ang_r;
  logic [ADDR_W-1:0]  base_r;
  logic [ADDR_W-1:0]  clr_addr_r;
  logic [ADDR_W-1:0]  rd_addr_r;

  logic                      v0_r, v1_r, v2_r, v3_r;
  logic [2*TRIG_W-1:0]       trig0_r;
  logic [ADDR_W-1:0]         base0_r, base1_r, base2_r;
  logic signed [PROD_W-1:0]  px1_r, py1_r;
  logic [ROW_W-1:0]          row2_r;
  logic [ADDR_W-1:0]         addr3_r;

  logic [COUNT_W-1:0] acc_mem [NCELL];
  logic [COUNT_W-1:0] rd_data_r;
  logic               mem_re, mem_we;
  logic [ADDR_W-1:0]  mem_raddr, mem_waddr;
  logic [COUNT_W-1:0] mem_wdata;

  logic [COUNT_W-1:0] out_count_r;
  logic               out_status_r;

  logic [CFG_W-1:0]          wl, hl;
  logic signed [TRIG_W-1:0]  cos0, sin0;
  logic signed [SUM_W-1:0]   sum2;
  logic [SUM_W-1:0]          abs2;
  logic [SUM_W:0]            rnd2;
  logic [MAG_W-1:0]          mag2;
  logic                      row_ok2;
  logic [ROW_W-1:0]          row2;

  // Configuration.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= CFG_DIM_RESET;
      height_r <= CFG_DIM_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_IMAGE_WIDTH:  width_r  <= cfg_wdata;
        CFG_IMAGE_HEIGHT: height_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Request capture.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      kind_r <= in_kind;
      x_r    <= in_pos_x;
      y_r    <= in_pos_y;
      pix_r  <= in_pixel;
      angf_r <= in_angle_index;
      rhof_r <= in_rho_index;
    end
  end

  assign wl = (width_r < DIM_LIM) ? width_r : DIM_LIM;
  assign hl = (height_r < DIM_LIM) ? height_r : DIM_LIM;

  // Flat address of a read; only used when the cell is in range.
  always_ff @(posedge clk) begin
    rd_addr_r <= ADDR_W'(angf_r) * ADDR_W'(NRHO) + ADDR_W'(rhof_r);
  end

  // Angle sweep and clearing counters; both wrap to zero after the last step.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ang_r      <= '0;
      base_r     <= '0;
      clr_addr_r <= '0;
    end else begin
      if (cmd.ang_step) begin
        if (sts.ang_last) begin
          ang_r  <= '0;
          base_r <= '0;
        end else begin
          ang_r  <= ang_r + 1'b1;
          base_r <= base_r + ADDR_W'(NRHO);
        end
      end
      if (cmd.clr_step) begin
        if (sts.clr_last) begin
          clr_addr_r <= '0;
        end else begin
          clr_addr_r <= clr_addr_r + 1'b1;
        end
      end
    end
  end

  // Vote pipeline: table lookup, products, rounding to a row, memory read,
  // saturating write-back.
  assign cos0 = trig0_r[TRIG_W-1:0];
  assign sin0 = trig0_r[2*TRIG_W-1:TRIG_W];

  assign sum2    = SUM_W'(px1_r) + SUM_W'(py1_r);
  assign abs2    = sum2[SUM_W-1] ? SUM_W'(-sum2) : SUM_W'(sum2);
  assign rnd2    = {1'b0, abs2} + (SUM_W+1)'(1 << (Q_FRAC - 1));
  assign mag2    = rnd2[SUM_W:Q_FRAC];
  assign row_ok2 = (mag2 <= MAG_W'(RHO_HALF));
  assign row2    = sum2[SUM_W-1] ? ROW_W'(RHO_HALF) - ROW_W'(mag2)
                                 : ROW_W'(RHO_HALF) + ROW_W'(mag2);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v0_r <= cmd.ang_step;
      v1_r <= v0_r;
      v2_r <= v1_r && row_ok2;
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    trig0_r <= TRIG_ROM[ang_r];
    base0_r <= base_r;
    px1_r   <= $signed({1'b0, x_r}) * cos0;
    py1_r   <= $signed({1'b0, y_r}) * sin0;
    base1_r <= base0_r;
    row2_r  <= row2;
    base2_r <= base1_r;
    addr3_r <= mem_raddr;
  end

  // Accumulator memory ports.
  assign mem_re    = v2_r || cmd.rd_issue;
  assign mem_raddr = cmd.rd_issue ? rd_addr_r : base2_r + ADDR_W'(row2_r);
  assign mem_we    = v3_r || cmd.clr_step;
  assign mem_waddr = cmd.clr_step ? clr_addr_r : addr3_r;
  assign mem_wdata = cmd.clr_step ? '0
                   : ((rd_data_r == '1) ? rd_data_r : rd_data_r + 1'b1);

  always_ff @(posedge clk) begin
    if (mem_we) acc_mem[mem_waddr] <= mem_wdata;
  end

  always_ff @(posedge clk) begin
    if (mem_re) rd_data_r <= acc_mem[mem_raddr];
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_count_r  <= (cmd.res_sel == RES_COUNT) ? rd_data_r : '0;
      out_status_r <= (cmd.res_sel == RES_ERR);
    end
  end

  assign out_count  = out_count_r;
  assign out_status = out_status_r;

  always_comb begin
    sts.kind      = kind_r;
    sts.in_range  = (x_r != '0) && (x_r <= wl) && (y_r != '0) && (y_r <= hl);
    sts.pix_nz    = (pix_r != '0);
    sts.rd_ok     = (angf_r < ANGF_W'(NTHETA)) && (rhof_r < RHOF_W'(NRHO));
    sts.ang_last  = (ang_r == ANG_W'(NTHETA - 1));
    sts.clr_last  = (clr_addr_r == ADDR_W'(NCELL - 1));
    sts.pipe_busy = v0_r || v1_r || v2_r || v3_r;
  end

endmodule

`default_nettype wire

/* rtl/hough_line_accumulator.sv */
// Top level of the Hough line accumulator: joins the controller and the
// datapath to the stream channels and the configuration port. Depends on
// hla_pkg, hla_ctrl and hla_dp.
//
// Usage. Requests arrive on the in_ channel: in_tuser carries the kind (vote a
// pixel, read one cell, clear the accumulator) and in_tdata the pixel
// coordinates, pixel value and cell address. Every request gives exactly one
// result on the out_ channel: a cell count for reads, and a status flag that
// is set for a vote outside the configured image or a read out of range.
// The block handles one request at a time. A vote in range with a nonzero
// pixel sweeps the 180 angle columns, one column per cycle, through a
// five-stage pipeline with a read and a write port on the accumulator memory;
// its result is loaded once the last angle has drained from the pipeline, and
// the next request is taken after that. A read gives its result after one
// memory read, a vote that casts nothing straight after decoding; both then
// return to idle for the next request. A clear writes zero to all 131220
// cells, one per cycle. After reset the same clearing pass runs, during which
// in_tready stays low; image width and height reset to 256 and may be written
// at any time the block is idle. Results wait in an output register:
// while the receiver stalls, the result holds steady and the next request is
// still taken, finishing up to the point where its own result is due.
`default_nettype none

module hough_line_accumulator (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  // Configuration port.
  input  wire logic                              cfg_we,
  input  wire logic [hla_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [hla_pkg::CFG_W-1:0]         cfg_wdata,
  // Request channel.
  input  wire logic                              in_tvalid,
  output logic                                   in_tready,
  // pos_x[8:0], pos_y[17:9], pixel[25:18], angle_index[33:26],
  // rho_index[43:34], zero fill[47:44]
  input  wire logic [hla_pkg::IN_DATA_W-1:0]     in_tdata,
  // kind[1:0]
  input  wire logic [hla_pkg::KIND_W-1:0]        in_tuser,
  // Result channel.
  output logic                                   out_tvalid,
  input  wire logic                              out_tready,
  // count[15:0]
  output logic [hla_pkg::OUT_DATA_W-1:0]         out_tdata,
  // status[0]
  output logic [0:0]                             out_tuser
);
  import hla_pkg::*;

  hla_cmd_t            cmd;
  hla_sts_t            sts;
  logic [COUNT_W-1:0]  count;
  logic                status;

  // The controller owns the handshakes; the datapath never sees them.
  hla_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .sts        (sts),
    .cmd        (cmd)
  );

  // Request fields are unpacked here, lowest field in the lowest bits.
  hla_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .in_kind        (in_tuser),
    .in_pos_x       (in_tdata[8:0]),
    .in_pos_y       (in_tdata[17:9]),
    .in_pixel       (in_tdata[25:18]),
    .in_angle_index (in_tdata[33:26]),
    .in_rho_index   (in_tdata[43:34]),
    .cmd            (cmd),
    .sts            (sts),
    .out_count      (count),
    .out_status     (status)
  );

  assign out_tdata = count;
  assign out_tuser = status;

endmodule

`default_nettype wire

/* rtl/hla_checker.sv */
// Port-level checks of the Hough line accumulator and the bind that attaches
// them to the top level. Depends on hla_pkg and hough_line_accumulator.
`default_nettype none

module hla_checker (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_tvalid,
  input  wire logic                          in_tready,
  input  wire logic                          out_tvalid,
  input  wire logic                          out_tready,
  input  wire logic [hla_pkg::OUT_DATA_W-1:0] out_tdata,
  input  wire logic [0:0]                    out_tuser
);
  import hla_pkg::*;

  // No result survives a reset.
  a_reset_clears_out: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  // The clearing pass after reset keeps the request side closed.
  a_init_clear: assert property (@(posedge clk) rst_n && $past(!rst_n) |-> !in_tready)
    else $error("request accepted during the clearing pass");

  // One request at a time: the block is busy in the cycle after acceptance.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("request accepted back to back");

  // An error result never carries a count.
  a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] |-> out_tdata == '0)
    else $error("error result with nonzero count");

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("stalled result changed");

endmodule

bind hough_line_accumulator hla_checker u_hla_checker (.*);

`default_nettype wire
